FILE: hw/rtl/wes_pkg.sv
// Shared types and constants for the wave equation stencil step.
package wes_pkg;

    localparam int SAMPLE_BITS    = 32;
    localparam int COEF_FRAC_BITS = 16;
    localparam int COEF_BITS      = COEF_FRAC_BITS + 2;
    localparam int SIZE_BITS      = 11;
    localparam int CFG_DATA_BITS  = COEF_BITS;
    localparam int CFG_INDEX_BITS = 2;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_COEF_X = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COEF_Y = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH  = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT = 2'd3;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    typedef struct packed {
        logic                          command;
        logic signed [SAMPLE_BITS-1:0] u_sample;
        logic signed [SAMPLE_BITS-1:0] prev_sample;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] new_sample;
        logic                          last_in_frame;
    } out_word_t;

    // one stencil's operands, centre then neighbours then previous step
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] c;
        logic signed [SAMPLE_BITS-1:0] l;
        logic signed [SAMPLE_BITS-1:0] r;
        logic signed [SAMPLE_BITS-1:0] b;
        logic signed [SAMPLE_BITS-1:0] a;
        logic signed [SAMPLE_BITS-1:0] p;
        logic                          last;
    } stencil_t;

endpackage

FILE: hw/rtl/wes_ram.sv
// Generic RAM, one write port and two registered read ports (read-old-data).
module wes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

FILE: hw/rtl/wes_front.sv
// Front end: raster position tracking, line stores and stencil operand gathering.
module wes_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  wes_pkg::in_word_t                   in_word,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      width_in_use,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]     height_in_use,
    input  logic [wes_pkg::QUEUE_CNT_BITS-1:0]  queue_count,
    output logic                                push,
    output wes_pkg::stencil_t                   push_word
);
    import wes_pkg::*;

    localparam int CLW = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);

    typedef struct packed {
        logic                          o_bank;
        logic                          below_is_u;
        logic                          above_is_below;
        logic                          first_col;
        logic                          last_col;
        logic                          last;
        logic signed [SAMPLE_BITS-1:0] u;
    } s1_ctl_t;

    logic [CLW-1:0] col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic           s1_valid_reg;
    s1_ctl_t        s1_reg, s1_next;
    logic signed [SAMPLE_BITS-1:0] l_reg;

    logic [CLW-1:0] col_eff;
    logic [RW-1:0]  row_eff;
    logic [WW-1:0]  col_inc;
    logic           accept, is_sample, draining, act, emit, we_sample;
    logic [SAMPLE_BITS-1:0] b0_c, b0_r, b1_c, b1_r, prev_q;
    logic signed [SAMPLE_BITS-1:0] c, rr, bl, lv;

    assign in_ready  = (QUEUE_CNT_BITS+1)'(queue_count) + (QUEUE_CNT_BITS+1)'(s1_valid_reg)
                       < (QUEUE_CNT_BITS+1)'(QUEUE_DEPTH);
    assign accept    = in_valid && in_ready;
    assign col_eff   = (WW'(col_reg) >= width_in_use) ? '0 : col_reg;
    assign row_eff   = (row_reg > height_in_use) ? height_in_use : row_reg;
    assign draining  = (row_eff >= height_in_use);
    assign is_sample = (in_word.command == CMD_SAMPLE);
    assign act       = accept && (is_sample ? !draining : draining);
    assign emit      = act && (!is_sample || row_eff != '0);
    assign we_sample = act && is_sample;
    assign col_inc   = WW'(col_eff) + WW'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (act)
        begin
            if (col_inc == width_in_use)
            begin
                col_next = '0;
                row_next = is_sample ? row_eff + RW'(1) : '0;
            end
            else
            begin
                col_next = CLW'(col_inc);
                row_next = row_eff;
            end
        end
        s1_next.o_bank         = is_sample ? ~row_eff[0] : ~height_in_use[0];
        s1_next.below_is_u     = is_sample && (row_eff < RW'(2));
        s1_next.above_is_below = !is_sample;
        s1_next.first_col      = (col_eff == '0);
        s1_next.last_col       = (col_inc == width_in_use);
        s1_next.last           = !is_sample && (col_inc == width_in_use);
        s1_next.u              = in_word.u_sample;
    end

    wes_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_bank0 (
        .clk(clk), .we(we_sample && !row_eff[0]), .waddr(col_eff), .wdata(in_word.u_sample),
        .raddr_a(col_eff), .rdata_a(b0_c), .raddr_b(CLW'(col_inc)), .rdata_b(b0_r)
    );
    wes_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_bank1 (
        .clk(clk), .we(we_sample && row_eff[0]), .waddr(col_eff), .wdata(in_word.u_sample),
        .raddr_a(col_eff), .rdata_a(b1_c), .raddr_b(CLW'(col_inc)), .rdata_b(b1_r)
    );
    wes_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_WIDTH)) u_prev (
        .clk(clk), .we(we_sample), .waddr(col_eff), .wdata(in_word.prev_sample),
        .raddr_a(col_eff), .rdata_a(prev_q), .raddr_b(col_eff), .rdata_b()
    );

    assign c  = s1_reg.o_bank ? b1_c : b0_c;
    assign rr = s1_reg.o_bank ? b1_r : b0_r;
    assign bl = s1_reg.below_is_u ? s1_reg.u : (s1_reg.o_bank ? b0_c : b1_c);
    assign lv = s1_reg.first_col ? rr : l_reg;

    assign push           = s1_valid_reg;
    assign push_word.c    = c;
    assign push_word.l    = lv;
    assign push_word.r    = s1_reg.last_col ? lv : rr;
    assign push_word.b    = bl;
    assign push_word.a    = s1_reg.above_is_below ? bl : s1_reg.u;
    assign push_word.p    = prev_q;
    assign push_word.last = s1_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_valid_reg)
        begin
            l_reg <= c;
        end
    end
endmodule

FILE: hw/rtl/wes_queue.sv
// Short queue of stencil operand words between front and back end.
module wes_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  wes_pkg::stencil_t                   push_word,
    input  logic                                pop,
    output logic                                not_empty,
    output wes_pkg::stencil_t                   head_word,
    output logic [wes_pkg::QUEUE_CNT_BITS-1:0]  count
);
    import wes_pkg::*;

    stencil_t                  mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg;

    assign not_empty = (count_reg != '0);
    assign head_word = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QUEUE_CNT_BITS'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QUEUE_CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg < QUEUE_CNT_BITS'(QUEUE_DEPTH))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue underflow");
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        push == pop |=> $stable(count_reg))
        else $error("queue count moved");
endmodule

FILE: hw/rtl/wes_back.sv
// Back end: stencil arithmetic pipeline with saturation and output register.
module wes_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           not_empty,
    input  wes_pkg::stencil_t              head_word,
    output logic                           pop,
    input  logic [wes_pkg::COEF_BITS-1:0]  coef_x,
    input  logic [wes_pkg::COEF_BITS-1:0]  coef_y,
    output logic                           out_valid,
    input  logic                           out_ready,
    output wes_pkg::out_word_t             out_word
);
    import wes_pkg::*;

    localparam int DW = SAMPLE_BITS + 2;
    localparam int PW = DW + COEF_BITS + 1;
    localparam int TW = PW - COEF_FRAC_BITS;
    localparam int SW = TW + 2;
    localparam logic signed [SW-1:0] SAT_MAX = {{(SW-SAMPLE_BITS+1){1'b0}},
                                                {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;

    logic                 en;
    logic                 a_valid_reg, b_valid_reg, out_valid_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, base_a_reg, base_b_reg;
    logic                 last_a_reg, last_b_reg;
    logic signed [PW-1:0] px_reg, py_reg;
    logic signed [DW-1:0] lx, rx, cx, bx, ax, px;
    logic signed [SW-1:0] sum;
    out_word_t            out_reg;

    assign en  = !out_valid_reg || out_ready;
    assign pop = en && not_empty;

    assign lx = DW'(head_word.l);
    assign rx = DW'(head_word.r);
    assign cx = DW'(head_word.c);
    assign bx = DW'(head_word.b);
    assign ax = DW'(head_word.a);
    assign px = DW'(head_word.p);

    assign sum = SW'(base_b_reg) + SW'(px_reg >>> COEF_FRAC_BITS)
                 + SW'(py_reg >>> COEF_FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= not_empty;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg     <= lx + rx - (cx <<< 1);
            dy_reg     <= bx + ax - (cx <<< 1);
            base_a_reg <= (cx <<< 1) - px;
            last_a_reg <= head_word.last;
            px_reg     <= dx_reg * $signed({1'b0, coef_x});
            py_reg     <= dy_reg * $signed({1'b0, coef_y});
            base_b_reg <= base_a_reg;
            last_b_reg <= last_a_reg;
            priority if (sum > SAT_MAX)
            begin
                out_reg.new_sample <= SAT_MAX[SAMPLE_BITS-1:0];
            end
            else if (sum < SAT_MIN)
            begin
                out_reg.new_sample <= SAT_MIN[SAMPLE_BITS-1:0];
            end
            else
            begin
                out_reg.new_sample <= sum[SAMPLE_BITS-1:0];
            end
            out_reg.last_in_frame <= last_b_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;
endmodule

FILE: hw/rtl/wave_equation_stencil_step.sv
// Top level of the 2-D wave equation five-point stencil step.
// Path to out_valid: front-end operand register, queue, back-end a and b stages, output register.
// Throughput: one word per cycle while in_ready is high; in_ready drops as the 4-deep queue fills.
// First row of a frame gives no results; drain words flush the last row.
// Reset: positions, queue and pipeline valids clear; coefficients 0, sizes at maximum capped at 1024.
// Line stores are not cleared; no clearing pass.
module wave_equation_stencil_step #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  wes_pkg::in_word_t                   in_word,
    output logic                                out_valid,
    input  logic                                out_ready,
    output wes_pkg::out_word_t                  out_word,
    input  logic                                cfg_we,
    input  logic [wes_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [wes_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import wes_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    logic [COEF_BITS-1:0] coef_x_reg, coef_y_reg;
    logic [WW-1:0]        width_reg;
    logic [RW-1:0]        height_reg;
    logic [SIZE_BITS-1:0] size_val;

    logic                      push, pop, not_empty;
    stencil_t                  push_word, head_word;
    logic [QUEUE_CNT_BITS-1:0] queue_count;

    assign size_val = cfg_data[SIZE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x_reg <= '0;
            coef_y_reg <= '0;
            width_reg  <= WW'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
            height_reg <= RW'(MAX_HEIGHT < 1024 ? MAX_HEIGHT : 1024);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COEF_X: coef_x_reg <= cfg_data;
                CFG_COEF_Y: coef_y_reg <= cfg_data;
                CFG_WIDTH:
                begin
                    priority if (size_val < SIZE_BITS'(2))
                        width_reg <= WW'(2);
                    else if (32'(size_val) > MAX_WIDTH)
                        width_reg <= WW'(MAX_WIDTH);
                    else
                        width_reg <= WW'(size_val);
                end
                CFG_HEIGHT:
                begin
                    priority if (size_val < SIZE_BITS'(2))
                        height_reg <= RW'(2);
                    else if (32'(size_val) > MAX_HEIGHT)
                        height_reg <= RW'(MAX_HEIGHT);
                    else
                        height_reg <= RW'(size_val);
                end
                default: ;
            endcase
        end
    end

    wes_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_word(in_word), .width_in_use(width_reg), .height_in_use(height_reg),
        .queue_count(queue_count), .push(push), .push_word(push_word)
    );

    wes_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_word(push_word), .pop(pop),
        .not_empty(not_empty), .head_word(head_word), .count(queue_count)
    );

    wes_back u_back (
        .clk(clk), .rst_n(rst_n), .not_empty(not_empty), .head_word(head_word), .pop(pop),
        .coef_x(coef_x_reg), .coef_y(coef_y_reg), .out_valid(out_valid),
        .out_ready(out_ready), .out_word(out_word)
    );
endmodule

FILE: tb/wave_equation_stencil_step_checker.sv
// Checker for the wave equation stencil step: predicts each point and compares the output words.
module wave_equation_stencil_step_checker
    import wes_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  in_word_t                  in_word,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  out_word_t                 out_word,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        pending,
    output int                        errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_MAX = 1024;

    logic signed [SAMPLE_BITS-1:0] u_rows [2][GRID_MAX];
    logic signed [SAMPLE_BITS-1:0] prev_row [GRID_MAX];
    logic [COEF_BITS-1:0]          cx, cy;
    int unsigned                   grid_w, grid_h, col, row;
    out_word_t                     points_due [$];

    function automatic int unsigned clamp_size(logic [SIZE_BITS-1:0] v);
        if (v < 2)
            return 2;
        return (v > GRID_MAX) ? GRID_MAX : v;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] wave_point(longint c, longint l,
            longint r, longint b, longint a, longint p);
        longint tx;
        longint ty;
        longint s;
        tx = (longint'(cx) * (l + r - 2 * c)) >>> COEF_FRAC_BITS;
        ty = (longint'(cy) * (b + a - 2 * c)) >>> COEF_FRAC_BITS;
        s  = 2 * c + tx + ty - p;
        if (s > 64'sh7FFF_FFFF)
            s = 64'sh7FFF_FFFF;
        if (s < -64'sh8000_0000)
            s = -64'sh8000_0000;
        return s[SAMPLE_BITS-1:0];
    endfunction

    task automatic report(string what, logic [SAMPLE_BITS-1:0] got, logic [SAMPLE_BITS-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic advance_grid(in_word_t w);
        int unsigned s;
        int unsigned o;
        int unsigned ci;
        int unsigned ri;
        longint c, l, r, b, a;
        out_word_t pt;
        ci = (col >= grid_w) ? 0 : col;
        ri = (row > grid_h) ? grid_h : row;
        if (w.command == CMD_SAMPLE)
        begin
            if (ri >= grid_h)
                return;
            s = ri & 1;
            o = s ^ 1;
            if (ri >= 1)
            begin
                c = u_rows[o][ci];
                l = (ci > 0) ? u_rows[o][ci-1] : u_rows[o][ci+1];
                r = (ci + 1 < grid_w) ? u_rows[o][ci+1] : u_rows[o][ci-1];
                a = w.u_sample;
                b = (ri >= 2) ? longint'(u_rows[s][ci]) : a;
                pt.new_sample    = wave_point(c, l, r, b, a, prev_row[ci]);
                pt.last_in_frame = 1'b0;
                points_due.push_back(pt);
            end
            u_rows[s][ci] = w.u_sample;
            prev_row[ci]  = w.prev_sample;
            ci++;
            if (ci >= grid_w)
            begin
                ci = 0;
                ri++;
            end
        end
        else
        begin
            if (ri < grid_h)
                return;
            o = (grid_h - 1) & 1;
            s = o ^ 1;
            c = u_rows[o][ci];
            l = (ci > 0) ? u_rows[o][ci-1] : u_rows[o][ci+1];
            r = (ci + 1 < grid_w) ? u_rows[o][ci+1] : u_rows[o][ci-1];
            b = u_rows[s][ci];
            pt.new_sample    = wave_point(c, l, r, b, b, prev_row[ci]);
            pt.last_in_frame = (ci + 1 == grid_w);
            points_due.push_back(pt);
            ci++;
            if (ci >= grid_w)
            begin
                ci = 0;
                ri = 0;
            end
        end
        col = ci;
        row = ri;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            cx      = '0;
            cy      = '0;
            grid_w  = GRID_MAX;
            grid_h  = GRID_MAX;
            col     = 0;
            row     = 0;
            errors  = 0;
            points_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COEF_X: cx = cfg_data;
                    CFG_COEF_Y: cy = cfg_data;
                    CFG_WIDTH:  grid_w = clamp_size(cfg_data[SIZE_BITS-1:0]);
                    CFG_HEIGHT: grid_h = clamp_size(cfg_data[SIZE_BITS-1:0]);
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (points_due.size() == 0)
                begin
                    report("unexpected word", out_word.new_sample, '0);
                end
                else
                begin
                    want = points_due.pop_front();
                    if (out_word.new_sample !== want.new_sample)
                        report("new_sample", out_word.new_sample, want.new_sample);
                    if (out_word.last_in_frame !== want.last_in_frame)
                        report("last_in_frame", out_word.last_in_frame, want.last_in_frame);
                end
            end
            if (in_valid && in_ready)
                advance_grid(in_word);
        end
        pending = points_due.size();
    end
endmodule

FILE: tb/wave_equation_stencil_step_tb.sv
// Testbench top for the wave equation stencil step: stimulus, clock, reset and verdict.
module wave_equation_stencil_step_tb;
    import wes_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    in_word_t                  in_word = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    out_word_t                 out_word;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    int                        pending;
    int                        errors;
    int                        cycles = 0;
    int                        idle_pct = 0;
    int                        stall_pct = 0;
    int                        words_sent = 0;

    wave_equation_stencil_step dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    wave_equation_stencil_step_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .pending(pending), .errors(errors)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        out_ready <= ($urandom_range(99) >= stall_pct);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int clamp_size(int v);
        if (v < 2)
            return 2;
        return (v > 1024) ? 1024 : v;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [COEF_BITS-1:0] pick_coef();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return COEF_BITS'($urandom_range(16383));
            default: return COEF_BITS'($urandom);
        endcase
    endfunction

    task automatic send(logic cmd);
        in_word_t w;
        w.command     = cmd;
        w.u_sample    = pick_sample();
        w.prev_sample = pick_sample();
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        words_sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic wait_settled();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_regs(logic [COEF_BITS-1:0] cxv, logic [COEF_BITS-1:0] cyv,
            int wcode, int hcode);
        cfg_we <= 1'b1;
        cfg_index <= CFG_COEF_X;
        cfg_data <= cxv;
        @(posedge clk);
        cfg_index <= CFG_COEF_Y;
        cfg_data <= cyv;
        @(posedge clk);
        cfg_index <= CFG_WIDTH;
        cfg_data <= CFG_DATA_BITS'(wcode);
        @(posedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data <= CFG_DATA_BITS'(hcode);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // one full frame: samples with stray drains, then drains with stray samples
    task automatic run_frame(logic [COEF_BITS-1:0] cxv, logic [COEF_BITS-1:0] cyv,
            int wcode, int hcode, bit hold_mid, int noise_pct);
        int wn;
        int hn;
        wn = clamp_size(wcode);
        hn = clamp_size(hcode);
        write_regs(cxv, cyv, wcode, hcode);
        for (int n = 0; n < wn * hn; n++)
        begin
            if ($urandom_range(99) < noise_pct)
                send(CMD_DRAIN);
            if (hold_mid && n == (wn * hn) / 2)
                wait_settled();
            send(CMD_SAMPLE);
        end
        for (int n = 0; n < wn; n++)
        begin
            if ($urandom_range(99) < noise_pct)
                send(CMD_SAMPLE);
            send(CMD_DRAIN);
        end
        wait_settled();
    endtask

    initial
    begin
        int frame_no;
        int wcode;
        int hcode;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: smallest grid via clamped codes, full-scale coefficients, stray words
        run_frame('1, '1, 1, 0, 1'b0, 40);
        run_frame('1, '0, 3, 3, 1'b1, 30);
        run_frame('0, '1, 40, 2, 1'b0, 0);

        frame_no = 0;
        while (words_sent < 2000)
        begin
            case (frame_no % 5)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 75;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 75;
                end
                3:
                begin
                    idle_pct = 22;
                    stall_pct = 22;
                end
                default:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
            endcase
            if (frame_no == 7)
            begin
                wcode = 2;
                hcode = 200;
            end
            else
            begin
                wcode = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 12);
                hcode = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 8);
            end
            run_frame(pick_coef(), pick_coef(), wcode, hcode, frame_no % 4 == 1, 5);
            frame_no++;
        end

        wait_settled();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
